/* rtl/rau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_DIVZERO  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL1,
      OP_MUL2,
      OP_MUL3,
      OP_COMBINE,
      OP_GCD_INIT,
      OP_GCD_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type     op;
   } dp_cmd_type;

   typedef struct packed {
      logic       den_zero;
      logic       bnum_zero;
      logic       is_div;
      logic       raw_zero;
      logic       gcd_done;
      logic       div_done;
   } dp_status_type;

endpackage
`default_nettype wire

/* rtl/rau_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand split, shared cross-product multiplier, binary GCD and a pair of
// restoring dividers that divide numerator and denominator by the GCD.
// Operands go into the cross products unreduced: the final reduction gives
// the same fraction, and with operands of at most 32 bits the raw numerator
// magnitude stays at most 2^63, so no overflow status can arise.
// ----------------------------------------------------------------------------
module rau_datapath #(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire                    clock,
   input  rau_pkg::dp_cmd_type    cmd,
   input  wire [1:0]              req_command,
   input  wire [31:0]             req_num_a,
   input  wire [31:0]             req_den_a,
   input  wire [31:0]             req_num_b,
   input  wire [31:0]             req_den_b,
   output rau_pkg::dp_status_type sts,
   output logic [63:0]            res_num,
   output logic [62:0]            res_den
);
   import rau_pkg::*;

   localparam int W = OPERAND_WIDTH;

   cmd_type      cmd_ff;
   logic [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic         as_ff, bs_ff;
   logic         den_zero_ff, bnum_zero_ff;
   logic [63:0]  t1_ff, t2_ff, mag_ff, den_ff;
   logic         neg_ff;
   logic [63:0]  gx_ff, gy_ff;
   logic [5:0]   gk_ff;
   logic [63:0]  div_ff;
   logic [63:0]  qm_ff, rm_ff, qd_ff, rd_ff;
   logic [6:0]   dc_ff;
   logic [63:0]  res_num_ff;
   logic [62:0]  res_den_ff;

   logic [W-1:0] na_w, da_w, nb_w, db_w;
   logic [31:0]  m_x, m_y;
   logic [63:0]  prod;
   logic         n1_eff, n2_eff;
   logic [63:0]  diff;
   logic         x_ge;
   logic [63:0]  gcd_val;
   logic [64:0]  trial_m, trial_d;

   function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
      return v[W-1] ? (~v + W'(1)) : v;
   endfunction

   assign na_w = req_num_a[W-1:0];
   assign da_w = req_den_a[W-1:0];
   assign nb_w = req_num_b[W-1:0];
   assign db_w = req_den_b[W-1:0];

   // single multiplier shared by the three cross products
   always_comb begin
      m_x = '0;
      m_y = '0;
      case (cmd.op)
         OP_MUL1: begin
            m_x = 32'(an_ff);
            m_y = (cmd_ff == CMD_MUL) ? 32'(bn_ff) : 32'(bd_ff);
         end
         OP_MUL2: begin
            m_x = 32'(ad_ff);
            m_y = (cmd_ff == CMD_MUL) ? 32'(bd_ff) : 32'(bn_ff);
         end
         OP_MUL3: begin
            m_x = 32'(ad_ff);
            m_y = 32'(bd_ff);
         end
         default: ;
      endcase
   end

   assign prod = 64'(m_x) * 64'(m_y);

   // a zero term takes the sign of the other one
   always_comb begin
      n1_eff = as_ff;
      n2_eff = (cmd_ff == CMD_SUB) ? ~bs_ff : bs_ff;
      if (t2_ff == 64'd0) n2_eff = n1_eff;
      if (t1_ff == 64'd0) n1_eff = n2_eff;
   end

   // binary gcd: strip common twos, then subtract-and-shift
   assign x_ge    = gx_ff >= gy_ff;
   assign diff    = x_ge ? gx_ff - gy_ff : gy_ff - gx_ff;
   assign gcd_val = (gx_ff == 64'd0 ? gy_ff : gx_ff) << gk_ff;

   assign trial_m = {rm_ff, qm_ff[63]} - {1'b0, div_ff};
   assign trial_d = {rd_ff, qd_ff[63]} - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            cmd_ff       <= cmd_type'(req_command);
            an_ff        <= magnitude(na_w);
            ad_ff        <= magnitude(da_w);
            bn_ff        <= magnitude(nb_w);
            bd_ff        <= magnitude(db_w);
            as_ff        <= na_w[W-1] ^ da_w[W-1];
            bs_ff        <= nb_w[W-1] ^ db_w[W-1];
            den_zero_ff  <= (da_w == '0) || (db_w == '0);
            bnum_zero_ff <= (nb_w == '0);
         end
         OP_MUL1: t1_ff  <= prod;
         OP_MUL2: t2_ff  <= prod;
         OP_MUL3: den_ff <= prod;
         OP_COMBINE: begin
            case (cmd_ff)
               CMD_MUL: begin
                  mag_ff <= t1_ff;
                  neg_ff <= as_ff ^ bs_ff;
               end
               CMD_DIV: begin
                  mag_ff <= t1_ff;
                  den_ff <= t2_ff;
                  neg_ff <= as_ff ^ bs_ff;
               end
               default: begin
                  if (n1_eff == n2_eff) begin
                     mag_ff <= t1_ff + t2_ff;
                     neg_ff <= n1_eff;
                  end else if (t1_ff >= t2_ff) begin
                     mag_ff <= t1_ff - t2_ff;
                     neg_ff <= n1_eff;
                  end else begin
                     mag_ff <= t2_ff - t1_ff;
                     neg_ff <= n2_eff;
                  end
               end
            endcase
         end
         OP_GCD_INIT: begin
            gx_ff <= mag_ff;
            gy_ff <= den_ff;
            gk_ff <= '0;
         end
         OP_GCD_STEP: begin
            if (gx_ff != 64'd0 && gy_ff != 64'd0) begin
               if (!gx_ff[0] && !gy_ff[0]) begin
                  gx_ff <= gx_ff >> 1;
                  gy_ff <= gy_ff >> 1;
                  gk_ff <= gk_ff + 6'd1;
               end else if (!gx_ff[0]) gx_ff <= gx_ff >> 1;
               else if (!gy_ff[0]) gy_ff <= gy_ff >> 1;
               else if (x_ge) gx_ff <= diff >> 1;
               else gy_ff <= diff >> 1;
            end
         end
         OP_DIV_INIT: begin
            div_ff <= gcd_val;
            qm_ff  <= mag_ff;
            rm_ff  <= '0;
            qd_ff  <= den_ff;
            rd_ff  <= '0;
            dc_ff  <= '0;
         end
         OP_DIV_STEP: begin
            // quotient bits shift in where dividend bits shift out
            qm_ff <= {qm_ff[62:0], ~trial_m[64]};
            qd_ff <= {qd_ff[62:0], ~trial_d[64]};
            rm_ff <= trial_m[64] ? {rm_ff[62:0], qm_ff[63]} : trial_m[63:0];
            rd_ff <= trial_d[64] ? {rd_ff[62:0], qd_ff[63]} : trial_d[63:0];
            dc_ff <= dc_ff + 7'd1;
         end
         OP_FINISH: begin
            res_num_ff <= neg_ff ? (~qm_ff + 64'd1) : qm_ff;
            res_den_ff <= qd_ff[62:0];
         end
         default: ;
      endcase
   end

   assign res_num = res_num_ff;
   assign res_den = res_den_ff;

   always_comb begin
      sts.den_zero  = den_zero_ff;
      sts.bnum_zero = bnum_zero_ff;
      sts.is_div    = (cmd_ff == CMD_DIV);
      sts.raw_zero  = (mag_ff == 64'd0);
      sts.gcd_done  = (gx_ff == 64'd0) || (gy_ff == 64'd0);
      sts.div_done  = (dc_ff == 7'd64);
   end

endmodule
`default_nettype wire

/* rtl/rau_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences argument checks, cross products and result reduction.
// ----------------------------------------------------------------------------
module rau_controller (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  rau_pkg::dp_status_type sts,
   output rau_pkg::dp_cmd_type    cmd,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic                   rsp_zero
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_ZCHK, S_GSTEP,
      S_DSTEP, S_DONE
   } state_type;

   state_type   state_ff;

   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE:  if (start) cmd.op = OP_LOAD;
         S_MUL1:  cmd.op = OP_MUL1;
         S_MUL2:  cmd.op = OP_MUL2;
         S_MUL3:  cmd.op = OP_MUL3;
         S_COMB:  cmd.op = OP_COMBINE;
         S_ZCHK:  if (!sts.raw_zero) cmd.op = OP_GCD_INIT;
         S_GSTEP: cmd.op = sts.gcd_done ? OP_DIV_INIT : OP_GCD_STEP;
         S_DSTEP: cmd.op = sts.div_done ? OP_FINISH : OP_DIV_STEP;
         default: cmd.op = OP_NONE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_valid  <= 1'b0;
         rsp_status <= ST_OK;
         rsp_zero   <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) state_ff <= S_CHECK;
            S_CHECK: begin
               if (sts.den_zero) begin
                  rsp_valid  <= 1'b1;
                  rsp_status <= ST_INVALID;
                  rsp_zero   <= 1'b1;
                  state_ff   <= S_IDLE;
               end else if (sts.is_div && sts.bnum_zero) begin
                  rsp_valid  <= 1'b1;
                  rsp_status <= ST_DIVZERO;
                  rsp_zero   <= 1'b1;
                  state_ff   <= S_IDLE;
               end else begin
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_MUL3;
            S_MUL3: state_ff <= S_COMB;
            S_COMB: state_ff <= S_ZCHK;
            S_ZCHK: begin
               if (sts.raw_zero) begin
                  rsp_valid  <= 1'b1;
                  rsp_status <= ST_OK;
                  rsp_zero   <= 1'b1;
                  state_ff   <= S_IDLE;
               end else begin
                  state_ff <= S_GSTEP;
               end
            end
            S_GSTEP: if (sts.gcd_done) state_ff <= S_DSTEP;
            S_DSTEP: if (sts.div_done) state_ff <= S_DONE;
            S_DONE: begin
               rsp_valid  <= 1'b1;
               rsp_status <= ST_OK;
               rsp_zero   <= 1'b0;
               state_ff   <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid);
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy);
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_zero);

endmodule
`default_nettype wire

/* rtl/rational_arith_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide two fractions with GCD reduction.
// A zero denominator or a zero divisor is answered straight after the checks,
// a zero result after the cross products, else after the GCD and division
// steps; the number of GCD steps depends on the operand bits.
// Throughput: one transaction at a time; the next is accepted at the earliest
// in the cycle the response is presented. The receiver cannot stall.
// Reset: synchronous, returns to idle with no response pending.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_command,
   input  wire  [31:0] req_num_a,
   input  wire  [31:0] req_den_a,
   input  wire  [31:0] req_num_b,
   input  wire  [31:0] req_den_b,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_num,
   output logic [62:0] rsp_result_den,
   output logic [1:0]  rsp_status
);
   import rau_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;
   logic          zero;
   logic [63:0]   num;
   logic [62:0]   den;

   rau_controller u_ctrl (
      .clock, .reset, .start, .busy, .sts, .cmd,
      .rsp_valid, .rsp_status, .rsp_zero(zero)
   );

   rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock, .cmd, .req_command, .req_num_a, .req_den_a,
      .req_num_b, .req_den_b, .sts, .res_num(num), .res_den(den)
   );

   assign rsp_result_num = zero ? 64'd0 : num;
   assign rsp_result_den = zero ? 63'd1 : den;

endmodule
`default_nettype wire
